// ===== rtl/tdr_pkg.sv =====
// Package for the tandem repeat run finder: payload structs, widths and limits.
// Used by every module under rtl; depends on nothing.
package tdr_pkg;

  localparam int unsigned MAX_PERIOD = 16;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned RUN_W      = 16;
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;
  } in_t;

  typedef struct packed {
    logic [RUN_W-1:0] run_length;
    logic [SYM_W-1:0] motif_char;
    logic             last_result;
  } out_t;

  // Control side of a finished answer handed from the scanner to the emitter
  typedef struct packed {
    logic             valid;
    logic [RUN_W-1:0] run_length;
  } ans_ctrl_t;

endpackage

// ===== rtl/tdr_scan.sv =====
// Sequence scanner: block fill, compare against the previous block, run tracking.
// Depends on tdr_pkg; feeds a finished answer to tdr_emit.
module tdr_scan #(
  parameter int unsigned MaxPeriod = tdr_pkg::MAX_PERIOD,
  localparam int unsigned PW = $clog2(MaxPeriod + 1),
  localparam int unsigned IW = (MaxPeriod > 1) ? $clog2(MaxPeriod) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tdr_pkg::CFG_W-1:0]    cfg_period_i,
  input  logic                         in_accept_i,
  input  tdr_pkg::in_t                 in_data_i,
  output tdr_pkg::ans_ctrl_t           ans_o,
  output logic [PW-1:0]                ans_count_o,
  output logic [tdr_pkg::SYM_W-1:0]    ans_motif_o [MaxPeriod]
);

  localparam int unsigned RW = tdr_pkg::RUN_W;
  localparam int unsigned SW = tdr_pkg::SYM_W;

  logic [PW-1:0] len_q, len_d;
  logic [PW-1:0] fill_q, fill_d;
  logic          have_q, have_d;
  logic          diff_q, diff_d;
  logic [RW-1:0] run_q, run_d;
  logic [RW-1:0] best_q, best_d;
  logic [SW-1:0] cur_q  [MaxPeriod];
  logic [SW-1:0] prev_q [MaxPeriod];
  logic [SW-1:0] bm_q   [MaxPeriod];

  logic [PW-1:0] pos_eff, pos_inc;
  logic [IW-1:0] idx;
  logic          blk_done, diff_n;
  logic [SW-1:0] cur_n  [MaxPeriod];
  logic [SW-1:0] prev_1 [MaxPeriod];
  logic [SW-1:0] bm_1   [MaxPeriod];
  logic [RW-1:0] run_1, best_1;
  logic [PW-1:0] fill_1;
  logic          have_1, diff_1;

  // Clamp the period to 1..MaxPeriod
  always_comb begin
    if (cfg_period_i == '0) begin
      len_d = PW'(1);
    end else if (32'(cfg_period_i) > MaxPeriod) begin
      len_d = PW'(MaxPeriod);
    end else begin
      len_d = PW'(cfg_period_i);
    end
  end

  assign pos_eff  = (fill_q >= len_q) ? '0 : fill_q;
  assign idx      = pos_eff[IW-1:0];
  assign pos_inc  = pos_eff + PW'(1);
  assign blk_done = (pos_inc == len_q);
  assign diff_n   = diff_q | (have_q && (prev_q[idx] != in_data_i.symbol));

  always_comb begin
    cur_n      = cur_q;
    cur_n[idx] = in_data_i.symbol;
  end

  // Close the block, if this byte completes one
  always_comb begin
    run_1  = run_q;
    best_1 = best_q;
    bm_1   = bm_q;
    prev_1 = prev_q;
    have_1 = have_q;
    diff_1 = diff_n;
    fill_1 = pos_inc;
    if (blk_done) begin
      if (have_q) begin
        if (!diff_n) begin
          run_1 = (run_q == tdr_pkg::RUN_MAX) ? run_q : run_q + RW'(1);
        end else begin
          if (best_q < run_q) begin
            best_1 = run_q;
            bm_1   = prev_q;
          end
          run_1 = RW'(1);
        end
      end
      prev_1 = cur_n;
      have_1 = 1'b1;
      diff_1 = 1'b0;
      fill_1 = '0;
    end
  end

  // Final check of the open run and the answer
  always_comb begin
    ans_o.valid = in_accept_i & in_data_i.last_symbol;
    if (have_1) begin
      ans_count_o = len_q;
      if (best_1 < run_1) begin
        ans_o.run_length = run_1;
        ans_motif_o      = prev_1;
      end else begin
        ans_o.run_length = best_1;
        ans_motif_o      = bm_1;
      end
    end else begin
      ans_count_o      = fill_1;
      ans_o.run_length = RW'(1);
      ans_motif_o      = cur_n;
    end
  end

  always_comb begin
    fill_d = fill_q;
    have_d = have_q;
    diff_d = diff_q;
    run_d  = run_q;
    best_d = best_q;
    if (cfg_we_i || (in_accept_i && in_data_i.last_symbol)) begin
      fill_d = '0;
      have_d = 1'b0;
      diff_d = 1'b0;
      run_d  = RW'(1);
      best_d = '0;
    end else if (in_accept_i) begin
      fill_d = fill_1;
      have_d = have_1;
      diff_d = diff_1;
      run_d  = run_1;
      best_d = best_1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= PW'(1);
      fill_q <= '0;
      have_q <= 1'b0;
      diff_q <= 1'b0;
      run_q  <= RW'(1);
      best_q <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q <= len_d;
      end
      fill_q <= fill_d;
      have_q <= have_d;
      diff_q <= diff_d;
      run_q  <= run_d;
      best_q <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i && !cfg_we_i) begin
      cur_q  <= cur_n;
      prev_q <= prev_1;
      bm_q   <= bm_1;
    end
  end

`ifndef ASSERT_OFF
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) && (32'(len_q) <= MaxPeriod))
    else $error("period register out of range");
  a_fill_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < len_q)
    else $error("fill position reached the period");
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q != '0)
    else $error("run count dropped to zero");
  a_answer_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ans_o.valid |-> (ans_count_o != '0) && (ans_count_o <= len_q))
    else $error("answer length outside 1..period");
`endif

endmodule

// ===== rtl/tdr_emit.sv =====
// Answer emitter: holds a copy of the run length and motif, sends one byte per transaction.
// Depends on tdr_pkg; loaded from tdr_scan.
module tdr_emit #(
  parameter int unsigned MaxPeriod = tdr_pkg::MAX_PERIOD,
  localparam int unsigned PW = $clog2(MaxPeriod + 1),
  localparam int unsigned IW = (MaxPeriod > 1) ? $clog2(MaxPeriod) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tdr_pkg::ans_ctrl_t           ans_i,
  input  logic [PW-1:0]                ans_count_i,
  input  logic [tdr_pkg::SYM_W-1:0]    ans_motif_i [MaxPeriod],
  output logic                         busy_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tdr_pkg::out_t                out_data_o
);

  logic                         busy_q;
  logic [IW-1:0]                idx_q;
  logic [PW-1:0]                cnt_q;
  logic [tdr_pkg::RUN_W-1:0]    run_q;
  logic [tdr_pkg::SYM_W-1:0]    motif_q [MaxPeriod];
  logic                         at_last;

  assign at_last = ((PW'(idx_q) + PW'(1)) == cnt_q);

  // free in the cycle the final byte leaves, so the next answer can load then
  assign busy_o                 = busy_q & ~(~out_stall_i & at_last);
  assign out_valid_o            = busy_q;
  assign out_data_o.run_length  = run_q;
  assign out_data_o.motif_char  = motif_q[idx_q];
  assign out_data_o.last_result = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (ans_i.valid) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && !out_stall_i) begin
      // advance, or drop busy after the final byte
      if (at_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ans_i.valid) begin
      cnt_q   <= ans_count_i;
      run_q   <= ans_i.run_length;
      motif_q <= ans_motif_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ans_i.valid |-> (!busy_q || (!out_stall_i && at_last)))
    else $error("answer loaded over one still draining");
  a_idx_in_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (PW'(idx_q) < cnt_q))
    else $error("motif index past answer length");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !out_stall_i && at_last && !ans_i.valid) |=> !busy_q)
    else $error("emitter kept going after the final byte");
`endif

endmodule

// ===== rtl/tandem_repeat_run_finder_core.sv =====
// Top level of the tandem repeat run finder: scanner plus answer emitter.
// Depends on tdr_pkg, tdr_scan and tdr_emit.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  in_data_i  (tdr_pkg::in_t)
//   out      output     out_valid_o/out_stall_i out_data_o (tdr_pkg::out_t)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (period_length)
//
// One input byte per cycle unless a final byte is stalled; each byte is scored in the cycle it is taken.
// A final byte loads the answer register; it then drains one motif byte per
// transaction, 1..period_length bytes in all, from the single answer buffer.
// A final byte is stalled until the cycle the previous answer's last byte
// leaves; others flow. Reset is immediate, no clearing pass; the period resets to 1.
module tandem_repeat_run_finder_core #(
  parameter int unsigned MaxPeriod = tdr_pkg::MAX_PERIOD
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tdr_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  tdr_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output tdr_pkg::out_t             out_data_o
);

  localparam int unsigned PW = $clog2(MaxPeriod + 1);

  tdr_pkg::ans_ctrl_t            ans;
  logic [PW-1:0]                 ans_count;
  logic [tdr_pkg::SYM_W-1:0]     ans_motif [MaxPeriod];
  logic                          busy;
  logic                          in_accept;
  logic                          cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  // hold a final byte until the answer buffer is free
  assign in_stall_o  = busy & in_data_i.last_symbol;
  assign in_accept   = in_valid_i & ~in_stall_o;

  tdr_scan #(
    .MaxPeriod (MaxPeriod)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_period_i (cfg_data_i),
    .in_accept_i  (in_accept),
    .in_data_i    (in_data_i),
    .ans_o        (ans),
    .ans_count_o  (ans_count),
    .ans_motif_o  (ans_motif)
  );

  tdr_emit #(
    .MaxPeriod (MaxPeriod)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ans_i        (ans),
    .ans_count_i  (ans_count),
    .ans_motif_i  (ans_motif),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
